/* src/lfos_pkg.sv */
// ----------------------------------------------------------------------------
// lfos_pkg
// Shared types, register indexes, mode codes and widths of the line follow
// and obstacle steering block.
// ----------------------------------------------------------------------------
package lfos_pkg;

  localparam int unsigned HOLD_TICKS_DEF     = 15;
  localparam int unsigned IMAGE_CENTER_X_DEF = 320;

  localparam int unsigned ADDR_W = 5;
  localparam int unsigned NUM_W  = 35;
  localparam int unsigned DEN_W  = 20;
  localparam int unsigned CNT_W  = 6;

  localparam logic [2:0] REG_FOLLOW_SPEED    = 3'd0;
  localparam logic [2:0] REG_FOLLOW_GAIN     = 3'd1;
  localparam logic [2:0] REG_LINE_CONF_MIN   = 3'd2;
  localparam logic [2:0] REG_AVOID_SPEED     = 3'd3;
  localparam logic [2:0] REG_AVOID_GAIN      = 3'd4;
  localparam logic [2:0] REG_CONE_CONF_MIN   = 3'd5;
  localparam logic [2:0] REG_CONE_BOTTOM_MIN = 3'd6;
  localparam logic [2:0] REG_RECOVER_GAIN    = 3'd7;

  typedef enum logic [1:0] {
    MODE_FOLLOW  = 2'd0,
    MODE_AVOID   = 2'd1,
    MODE_RECOVER = 2'd2
  } mode_e;

  typedef struct packed {
    logic [11:0] follow_speed;
    logic [15:0] follow_gain;
    logic [7:0]  line_conf_min;
    logic [11:0] avoid_speed;
    logic [15:0] avoid_gain;
    logic [7:0]  cone_conf_min;
    logic [9:0]  cone_bottom_min;
    logic [15:0] recover_gain;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [15:0]      m0;
    logic [9:0]       m1;
    logic [7:0]       m2;
    logic [DEN_W-1:0] den;
  } unit_req_t;

  typedef struct packed {
    logic             done;
    logic [NUM_W-1:0] quot;
  } unit_rsp_t;

  typedef struct packed {
    logic        sat;
    logic [15:0] steer;
  } steer_t;

  function automatic steer_t sat_steer(input logic [NUM_W-1:0] mag, input logic neg);
    steer_t r;
    r.sat   = 1'b0;
    r.steer = 16'd0;
    if (neg) begin
      if (mag > NUM_W'(32768)) begin
        r.sat   = 1'b1;
        r.steer = 16'h8000;
      end else begin
        r.steer = 16'd0 - mag[15:0];
      end
    end else begin
      if (mag > NUM_W'(32767)) begin
        r.sat   = 1'b1;
        r.steer = 16'h7FFF;
      end else begin
        r.steer = mag[15:0];
      end
    end
    return r;
  endfunction

endpackage

/* src/lfos_regs.sv */
// ----------------------------------------------------------------------------
// lfos_regs
// APB configuration registers of the steering block.
// ----------------------------------------------------------------------------
module lfos_regs import lfos_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t       cfg_q;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{follow_speed:    12'd0,
                 follow_gain:     16'd0,
                 line_conf_min:   8'd128,
                 avoid_speed:     12'd0,
                 avoid_gain:      16'd0,
                 cone_conf_min:   8'd128,
                 cone_bottom_min: 10'd0,
                 recover_gain:    16'd0};
    end else if (wr_en) begin
      case (idx)
        REG_FOLLOW_SPEED:    cfg_q.follow_speed    <= pwdata[11:0];
        REG_FOLLOW_GAIN:     cfg_q.follow_gain     <= pwdata[15:0];
        REG_LINE_CONF_MIN:   cfg_q.line_conf_min   <= pwdata[7:0];
        REG_AVOID_SPEED:     cfg_q.avoid_speed     <= pwdata[11:0];
        REG_AVOID_GAIN:      cfg_q.avoid_gain      <= pwdata[15:0];
        REG_CONE_CONF_MIN:   cfg_q.cone_conf_min   <= pwdata[7:0];
        REG_CONE_BOTTOM_MIN: cfg_q.cone_bottom_min <= pwdata[9:0];
        REG_RECOVER_GAIN:    cfg_q.recover_gain    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_FOLLOW_SPEED:    prdata = 32'(cfg_q.follow_speed);
      REG_FOLLOW_GAIN:     prdata = 32'(cfg_q.follow_gain);
      REG_LINE_CONF_MIN:   prdata = 32'(cfg_q.line_conf_min);
      REG_AVOID_SPEED:     prdata = 32'(cfg_q.avoid_speed);
      REG_AVOID_GAIN:      prdata = 32'(cfg_q.avoid_gain);
      REG_CONE_CONF_MIN:   prdata = 32'(cfg_q.cone_conf_min);
      REG_CONE_BOTTOM_MIN: prdata = 32'(cfg_q.cone_bottom_min);
      REG_RECOVER_GAIN:    prdata = 32'(cfg_q.recover_gain);
      default:             prdata = 32'd0;
    endcase
  end

endmodule

/* src/lfos_unit.sv */
// ----------------------------------------------------------------------------
// lfos_unit
// Shared multiply and divide unit: (m0*m1*m2 + den/2) / den, two multiply
// steps and a rounding add followed by a restoring division of one quotient bit per cycle.
// ----------------------------------------------------------------------------
module lfos_unit import lfos_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  unit_req_t req_i,
  output unit_rsp_t rsp_o
);

  typedef enum logic [2:0] {
    U_IDLE,
    U_MUL1,
    U_MUL2,
    U_ADD,
    U_DIV,
    U_DONE
  } ustate_e;

  ustate_e          state_q;
  logic [15:0]      m0_q;
  logic [9:0]       m1_q;
  logic [7:0]       m2_q;
  logic [DEN_W-1:0] den_q;
  logic [33:0]      prod_q;
  logic [NUM_W-1:0] quot_q;
  logic [DEN_W-1:0] rem_q;
  logic [CNT_W-1:0] cnt_q;

  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  assign trial = {rem_q, quot_q[NUM_W-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  assign rsp_o.done = (state_q == U_DONE);
  assign rsp_o.quot = quot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
      m0_q    <= '0;
      m1_q    <= '0;
      m2_q    <= '0;
      den_q   <= '0;
      prod_q  <= '0;
      quot_q  <= '0;
      rem_q   <= '0;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        U_IDLE: begin
          if (req_i.start) begin
            m0_q    <= req_i.m0;
            m1_q    <= req_i.m1;
            m2_q    <= req_i.m2;
            den_q   <= req_i.den;
            state_q <= U_MUL1;
          end
        end
        U_MUL1: begin
          prod_q  <= 34'(m0_q * m1_q);
          state_q <= U_MUL2;
        end
        U_MUL2: begin
          prod_q  <= 34'(prod_q[25:0] * m2_q);
          state_q <= U_ADD;
        end
        U_ADD: begin
          quot_q  <= {1'b0, prod_q} + NUM_W'(den_q >> 1);
          rem_q   <= '0;
          cnt_q   <= '0;
          state_q <= U_DIV;
        end
        U_DIV: begin
          rem_q  <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
          quot_q <= {quot_q[NUM_W-2:0], ge};
          cnt_q  <= cnt_q + CNT_W'(1);
          if (cnt_q == CNT_W'(NUM_W - 1)) begin
            state_q <= U_DONE;
          end
        end
        U_DONE: begin
          state_q <= U_IDLE;
        end
        default: begin
          state_q <= U_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/line_follow_obstacle_steering.sv */
// ----------------------------------------------------------------------------
// line_follow_obstacle_steering
// Drive mode sequencer with line following and cone avoidance steering.
// ----------------------------------------------------------------------------
// One input word per control tick carries a track-centre point and one cone
// box; one output word per tick carries the drive command and the mode.
// Both channels use valid/ready; configuration goes through the APB port;
// the user writes it only while the block is idle, the block does not enforce this.
// A tick that needs a division (line following with a valid point, avoidance
// except with a cone right of centre within the gain cap) waits for the
// shared unit: two multiply steps, one rounding add and 35 quotient bits,
// one per cycle. Other ticks skip the unit.
// Throughput: one word at a time; in_ready_o rises again once the result
// sits in the output register.
// Reset clears the mode to follow, the held steering, the tick counter and
// the configuration to its reset values.
// A stalled receiver holds the output word; the block still accepts the next
// tick and parks its result until the output register frees up.
// ----------------------------------------------------------------------------
module line_follow_obstacle_steering import lfos_pkg::*; #(
  parameter int unsigned HOLD_TICKS     = HOLD_TICKS_DEF,
  parameter int unsigned IMAGE_CENTER_X = IMAGE_CENTER_X_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic              line_present_i,
  input  logic              line_point_valid_i,
  input  logic [9:0]        line_x_i,
  input  logic [9:0]        line_y_i,
  input  logic [7:0]        line_conf_i,
  input  logic              cone_present_i,
  input  logic [9:0]        cone_left_i,
  input  logic [9:0]        cone_top_i,
  input  logic [9:0]        cone_width_i,
  input  logic [9:0]        cone_height_i,
  input  logic [7:0]        cone_conf_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic              command_valid_o,
  output logic [11:0]       linear_speed_o,
  output logic signed [15:0] angular_speed_o,
  output logic [1:0]        drive_mode_o,
  output logic              steer_saturated_o
);

  localparam logic [9:0]       CX         = 10'(IMAGE_CENTER_X);
  localparam logic [7:0]       HOLD       = 8'(HOLD_TICKS);
  localparam logic [DEN_W-1:0] FOLLOW_DEN = DEN_W'(896 * IMAGE_CENTER_X);

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECIDE,
    S_WAIT,
    S_FIN
  } state_e;

  cfg_t      cfg;
  unit_req_t req;
  unit_rsp_t rsp;

  state_e      state_q;
  mode_e       mode_q;
  logic [15:0] last_q;
  logic [7:0]  ticks_q;
  logic        once_q;

  logic        p_valid_q;
  logic [11:0] p_speed_q;
  logic        p_neg_q;
  logic        p_upd_q;
  logic [15:0] p_steer_q;
  logic        p_sat_q;

  logic        out_valid_q;
  logic        cmd_q;
  logic [11:0] spd_q;
  logic [15:0] ang_q;
  logic [1:0]  mode_out_q;
  logic        sat_q;

  logic        lp_q, pv_q, cp_q;
  logic [9:0]  lx_q, ly_q, cl_q, ct_q, cw_q, ch_q;
  logic [7:0]  lc_q, cc_q;

  logic              close;
  logic [7:0]        ticks_inc;
  logic [10:0]       a_ctr;
  logic signed [12:0] a_off;
  logic signed [12:0] a_offc;
  logic [12:0]       a_mag;
  logic [12:0]       a_den;
  logic signed [10:0] f_off;
  logic [10:0]       f_abs;
  logic [9:0]        f_mo;
  logic [9:0]        f_y;
  logic [7:0]        f_yr;
  logic [18:0]       r_sum;

  mode_e             mode_d;
  logic [7:0]        ticks_d;
  logic              once_d;
  logic              d_valid;
  logic [11:0]       d_speed;
  logic              d_neg;
  logic              d_div;
  logic              d_upd;
  logic              d_use_last;
  logic [NUM_W-1:0]  d_mag;
  steer_t            d_st;
  steer_t            w_st;

  lfos_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  lfos_unit u_unit (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  assign in_ready_o        = (state_q == S_IDLE);
  assign out_valid_o       = out_valid_q;
  assign command_valid_o   = cmd_q;
  assign linear_speed_o    = spd_q;
  assign angular_speed_o   = $signed(ang_q);
  assign drive_mode_o      = mode_out_q;
  assign steer_saturated_o = sat_q;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      lp_q <= line_present_i;
      pv_q <= line_point_valid_i;
      lx_q <= line_x_i;
      ly_q <= line_y_i;
      lc_q <= line_conf_i;
      cp_q <= cone_present_i;
      cl_q <= cone_left_i;
      ct_q <= cone_top_i;
      cw_q <= cone_width_i;
      ch_q <= cone_height_i;
      cc_q <= cone_conf_i;
    end
  end

  always_comb begin
    ticks_inc = (ticks_q != 8'hFF) ? ticks_q + 8'd1 : ticks_q;
    close     = cp_q && (cc_q >= cfg.cone_conf_min) &&
                (({1'b0, ct_q} + {1'b0, ch_q}) >= {1'b0, cfg.cone_bottom_min});

    a_ctr = {1'b0, cl_q} + {2'b0, cw_q[9:1]};
    a_off = $signed({2'b0, a_ctr}) - $signed({3'b0, CX});
    if (a_off >= 0 && a_off < 13'sd5) begin
      a_offc = 13'sd5;
    end else if (a_off < 0 && a_off > -13'sd5) begin
      a_offc = -13'sd5;
    end else begin
      a_offc = a_off;
    end
    a_mag = a_offc[12] ? 13'(-a_offc) : 13'(a_offc);
    a_den = {a_mag[10:0], 2'b00};

    f_off = $signed({1'b0, lx_q}) - $signed({1'b0, CX});
    f_abs = f_off[10] ? 11'(-f_off) : 11'(f_off);
    f_mo  = (f_abs < 11'd5) ? 10'd0 : f_abs[9:0];
    f_y   = (ly_q > 10'd256) ? ly_q - 10'd256 : 10'd0;
    f_yr  = (f_y > 10'd224) ? 8'd224 : f_y[7:0];

    r_sum = {3'b0, cfg.recover_gain} + {2'b0, cfg.recover_gain, 1'b0} + 19'd4;

    mode_d     = mode_q;
    ticks_d    = ticks_inc;
    once_d     = once_q;
    d_valid    = 1'b0;
    d_speed    = 12'd0;
    d_neg      = 1'b0;
    d_div      = 1'b0;
    d_upd      = 1'b0;
    d_use_last = 1'b0;
    d_mag      = '0;
    req.m0     = cfg.follow_gain;
    req.m1     = f_mo;
    req.m2     = f_yr;
    req.den    = FOLLOW_DEN;

    if (lp_q) begin
      if (close) begin
        mode_d  = MODE_AVOID;
        ticks_d = 8'd0;
        once_d  = 1'b1;
      end
      case (close ? MODE_AVOID : mode_q)
        MODE_AVOID: begin
          if (close) begin
            if (cw_q != 10'd0) begin
              d_valid = 1'b1;
              d_speed = cfg.avoid_speed;
              d_upd   = 1'b1;
              d_neg   = !a_offc[12];
              req.m0  = cfg.avoid_gain;
              req.m1  = CX;
              req.m2  = 8'd1;
              req.den = DEN_W'(a_den);
              if (!a_offc[12] && ({3'b0, CX} >= a_den)) begin
                d_mag = NUM_W'(cfg.avoid_gain);
              end else begin
                d_div = 1'b1;
              end
            end
          end else if (once_q && ticks_inc < HOLD) begin
            d_valid    = 1'b1;
            d_speed    = cfg.avoid_speed;
            d_use_last = 1'b1;
          end else begin
            mode_d = MODE_RECOVER;
          end
        end
        MODE_RECOVER: begin
          if (pv_q && lc_q >= cfg.line_conf_min) begin
            mode_d = MODE_FOLLOW;
          end else begin
            d_valid = 1'b1;
            d_speed = cfg.follow_speed;
            d_neg   = !last_q[15];
            d_mag   = NUM_W'(r_sum[18:3]);
          end
        end
        default: begin
          mode_d = MODE_FOLLOW;
          if (pv_q) begin
            d_valid = 1'b1;
            d_speed = cfg.follow_speed;
            d_neg   = f_off[10];
            d_div   = 1'b1;
          end
        end
      endcase
    end

    req.start = (state_q == S_DECIDE) && d_div;

    if (d_use_last) begin
      d_st.sat   = 1'b0;
      d_st.steer = last_q;
    end else if (d_valid) begin
      d_st = sat_steer(d_mag, d_neg);
    end else begin
      d_st = '0;
    end

    w_st = sat_steer(rsp.quot, p_neg_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      mode_q      <= MODE_FOLLOW;
      last_q      <= '0;
      ticks_q     <= '0;
      once_q      <= 1'b0;
      p_valid_q   <= 1'b0;
      p_speed_q   <= '0;
      p_neg_q     <= 1'b0;
      p_upd_q     <= 1'b0;
      p_steer_q   <= '0;
      p_sat_q     <= 1'b0;
      out_valid_q <= 1'b0;
      cmd_q       <= 1'b0;
      spd_q       <= '0;
      ang_q       <= '0;
      mode_out_q  <= MODE_FOLLOW;
      sat_q       <= 1'b0;
    end else begin
      if (out_valid_q && out_ready_i && state_q != S_FIN) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          mode_q    <= mode_d;
          ticks_q   <= ticks_d;
          once_q    <= once_d;
          p_valid_q <= d_valid;
          p_speed_q <= d_speed;
          p_neg_q   <= d_neg;
          p_upd_q   <= d_upd;
          p_steer_q <= d_st.steer;
          p_sat_q   <= d_st.sat;
          if (d_div) begin
            state_q <= S_WAIT;
          end else begin
            if (d_upd) begin
              last_q <= d_st.steer;
            end
            state_q <= S_FIN;
          end
        end
        S_WAIT: begin
          if (rsp.done) begin
            p_steer_q <= w_st.steer;
            p_sat_q   <= w_st.sat;
            if (p_upd_q) begin
              last_q <= w_st.steer;
            end
            state_q <= S_FIN;
          end
        end
        S_FIN: begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_q <= 1'b1;
            cmd_q       <= p_valid_q;
            spd_q       <= p_valid_q ? p_speed_q : 12'd0;
            ang_q       <= p_valid_q ? p_steer_q : 16'd0;
            sat_q       <= p_valid_q && p_sat_q;
            mode_out_q  <= mode_q;
            state_q     <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* src/lfos_checker.sv */
// ----------------------------------------------------------------------------
// lfos_checker
// Port-level checks of the steering block, bound to the top level.
// ----------------------------------------------------------------------------
module lfos_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_o,
  input logic              out_valid_o,
  input logic              out_ready_i,
  input logic              command_valid_o,
  input logic [11:0]       linear_speed_o,
  input logic signed [15:0] angular_speed_o,
  input logic [1:0]        drive_mode_o,
  input logic              steer_saturated_o
);

  a_busy_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o
  ) else $error("block took a second word while busy");

  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(command_valid_o) &&
      $stable(linear_speed_o) && $stable(angular_speed_o) && $stable(drive_mode_o) &&
      $stable(steer_saturated_o)
  ) else $error("stalled output word changed");

  a_no_cmd_zero: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !command_valid_o |->
      linear_speed_o == 12'd0 && angular_speed_o == 16'sd0 && !steer_saturated_o
  ) else $error("withheld command carries nonzero fields");

  a_sat_limit: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && steer_saturated_o |->
      command_valid_o && (angular_speed_o == 16'sh7FFF || angular_speed_o == 16'sh8000)
  ) else $error("saturated steering not at a rail");

endmodule

bind line_follow_obstacle_steering lfos_checker u_lfos_checker (.*);
